/* sv/hepac_pkg.sv */
`timescale 1ns / 1ps
package hepac_pkg;

    typedef struct packed {
        logic        kind;
        logic [2:0]  ru_code;
        logic [1:0]  bw_code;
        logic [9:0]  ampdu_count;
        logic [15:0] mpdu_bits;
        logic [7:0]  beamformee_count;
    } t_req;

    typedef struct packed {
        logic [23:0] duration_us;
        logic [2:0]  status;
    } t_rsp;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_MCS  = 3'd1;
    localparam logic [2:0] ST_BAD_RU   = 3'd2;
    localparam logic [2:0] ST_RU_WIDTH = 3'd3;
    localparam logic [2:0] ST_BAD_ANT  = 3'd4;
    localparam logic [2:0] ST_NO_BFEE  = 3'd5;

    localparam logic       CFG_MCS = 1'b0;
    localparam logic       CFG_ANT = 1'b1;

    localparam logic [3:0] MCS_SUPPORTED = 4'd6;
    localparam logic [3:0] ANT_SOUNDING  = 4'd4;
    localparam logic [2:0] RU_INVALID    = 3'd7;
    localparam logic [2:0] RU_106        = 3'd2;

    // Reciprocal scale for the symbol count division.
    localparam int unsigned RECIP_SHIFT = 36;

    // Fixed sounding figures for four AP antennas. NDPA and BRP each fit in one
    // symbol on any full channel width (53 us). The leading part is NDPA + 16 + 40.
    localparam logic [6:0] SND_LEAD      = 7'd109;
    // Per sequence: 16 + BRP + 16 + CBR, CBR being 121 us on RU 106, 108 us above.
    localparam logic [7:0] SND_SEQ_RU106 = 8'd206;
    localparam logic [7:0] SND_SEQ_WIDE  = 8'd193;

    function automatic logic [13:0] f_ndbps(input logic [2:0] ru);
        logic [13:0] n;
        case (ru)
            3'd0:    n = 14'd108;
            3'd1:    n = 14'd216;
            3'd2:    n = 14'd459;
            3'd3:    n = 14'd1053;
            3'd4:    n = 14'd2106;
            3'd5:    n = 14'd4410;
            3'd6:    n = 14'd8820;
            default: n = 14'd108;
        endcase
        return n;
    endfunction

    function automatic logic [29:0] f_recip(input logic [2:0] ru);
        logic [63:0] m;
        case (ru)
            3'd0:    m = (64'd1 << 36) / 64'd108;
            3'd1:    m = (64'd1 << 36) / 64'd216;
            3'd2:    m = (64'd1 << 36) / 64'd459;
            3'd3:    m = (64'd1 << 36) / 64'd1053;
            3'd4:    m = (64'd1 << 36) / 64'd2106;
            3'd5:    m = (64'd1 << 36) / 64'd4410;
            3'd6:    m = (64'd1 << 36) / 64'd8820;
            default: m = (64'd1 << 36) / 64'd108;
        endcase
        return m[29:0];
    endfunction

endpackage

/* sv/he_ppdu_airtime_calculator.sv */
`timescale 1ns / 1ps
// HE PPDU airtime calculator for MCS 6 and one spatial stream. Each request
// yields exactly one response with a duration in microseconds and a status
// code; the duration is zero whenever the status is not OK. Kind 0 gives the
// A-MPDU airtime from the MPDU length, MPDU count and RU size; kind 1 gives
// the sounding sequence duration for four AP antennas from the RU size, the
// channel width and the beamformee count. The block is a six-register
// pipeline: a request may enter every cycle while the output is not stalled,
// and its response leaves from the last register. The pipeline depth is set
// by the symbol count division, done as a reciprocal multiply, a back
// multiply with a one-step correction, and a multiply by 136/10. A stall on
// the response side holds the whole pipeline.
// The two configuration registers (MCS index, AP antenna count) are written
// through a plain write port and should only change while no request is in
// flight.
module he_ppdu_airtime_calculator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  hepac_pkg::t_req   i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output hepac_pkg::t_rsp   o_out_rsp,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [3:0]        i_cfg_wdata
);

    logic [3:0] r_mcs;
    logic [3:0] r_ant;

    // The whole pipeline moves together whenever the output can take data.
    logic en;
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mcs <= hepac_pkg::MCS_SUPPORTED;
            r_ant <= hepac_pkg::ANT_SOUNDING;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == hepac_pkg::CFG_MCS) begin
                r_mcs <= i_cfg_wdata;
            end else begin
                r_ant <= i_cfg_wdata;
            end
        end
    end

    // Stage 1: request checks, PSDU size, sounding sequence count.
    logic [2:0] n_status;
    logic [3:0] n_shift;
    logic [8:0] n_bsum;
    logic [6:0] n_nseq;
    logic [7:0] n_seqcost;
    logic [2:0] fit_max;

    always_comb begin
        fit_max   = {1'b0, i_in_req.bw_code} + 3'd3;
        n_shift   = 4'd2 + {1'b0, fit_max} - {1'b0, i_in_req.ru_code};
        n_bsum    = {1'b0, i_in_req.beamformee_count} + ((9'd1 << n_shift) - 9'd1);
        n_nseq    = 7'(n_bsum >> n_shift);
        n_seqcost = (i_in_req.ru_code == hepac_pkg::RU_106) ? hepac_pkg::SND_SEQ_RU106
                                                            : hepac_pkg::SND_SEQ_WIDE;
        n_status  = hepac_pkg::ST_OK;
        if (!i_in_req.kind) begin
            if (r_mcs != hepac_pkg::MCS_SUPPORTED) begin
                n_status = hepac_pkg::ST_BAD_MCS;
            end else if (i_in_req.ru_code == hepac_pkg::RU_INVALID) begin
                n_status = hepac_pkg::ST_BAD_RU;
            end
        end else begin
            if (r_ant != hepac_pkg::ANT_SOUNDING) begin
                n_status = hepac_pkg::ST_BAD_ANT;
            end else if (i_in_req.beamformee_count == 8'd0) begin
                n_status = hepac_pkg::ST_NO_BFEE;
            end else if (i_in_req.ru_code < hepac_pkg::RU_106 ||
                         i_in_req.ru_code == hepac_pkg::RU_INVALID) begin
                n_status = hepac_pkg::ST_BAD_RU;
            end else if (r_mcs != hepac_pkg::MCS_SUPPORTED) begin
                n_status = hepac_pkg::ST_BAD_MCS;
            end else if (i_in_req.ru_code > fit_max) begin
                n_status = hepac_pkg::ST_RU_WIDTH;
            end
        end
    end

    logic [5:0]  r_vld;
    logic [2:0]  r_st   [1:5];
    logic        r_kind [1:5];
    logic [26:0] r1_psdu;
    logic [2:0]  r1_ru;
    logic [6:0]  r1_nseq;
    logic [7:0]  r1_cost;
    logic [14:0] r_k1dur [2:5];
    logic [27:0] r2_x;
    logic [57:0] r2_p;
    logic [13:0] r2_n;
    logic [27:0] r3_x;
    logic [35:0] r3_qn;
    logic [21:0] r3_qe;
    logic [13:0] r3_n;
    logic [29:0] r4_t;
    logic [61:0] r5_p;
    hepac_pkg::t_rsp r_out;

    logic [13:0] n1_n;
    logic [27:0] n2_x;
    logic [27:0] n4_r;
    logic [21:0] n4_q;
    logic [23:0] n5_dur;
    hepac_pkg::t_rsp n_out;

    assign n1_n = hepac_pkg::f_ndbps(r1_ru);
    assign n2_x = {1'b0, r1_psdu} + 28'd21 + {14'd0, n1_n};
    assign n4_r = r3_x - r3_qn[27:0];
    assign n4_q = r3_qe + ((n4_r >= {14'd0, r3_n}) ? 22'd1 : 22'd0);

    always_comb begin
        n5_dur = 24'd40 + r5_p[58:35];
        n_out.status = r_st[5];
        if (r_st[5] != hepac_pkg::ST_OK) begin
            n_out.duration_us = 24'd0;
        end else if (r_kind[5]) begin
            n_out.duration_us = {9'd0, r_k1dur[5]};
        end else begin
            n_out.duration_us = n5_dur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[4:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_st[1]   <= n_status;
            r_kind[1] <= i_in_req.kind;
            r1_psdu   <= 27'((17'd352 + {1'b0, i_in_req.mpdu_bits}) * i_in_req.ampdu_count);
            r1_ru     <= i_in_req.ru_code;
            r1_nseq   <= n_nseq;
            r1_cost   <= n_seqcost;

            r_st[2]    <= r_st[1];
            r_kind[2]  <= r_kind[1];
            r_k1dur[2] <= 15'(r1_cost * r1_nseq) + {8'd0, hepac_pkg::SND_LEAD};
            r2_x       <= n2_x;
            r2_p       <= n2_x * hepac_pkg::f_recip(r1_ru);
            r2_n       <= n1_n;

            r_st[3]    <= r_st[2];
            r_kind[3]  <= r_kind[2];
            r_k1dur[3] <= r_k1dur[2];
            r3_x       <= r2_x;
            r3_qe      <= r2_p[57:hepac_pkg::RECIP_SHIFT];
            r3_qn      <= r2_p[57:hepac_pkg::RECIP_SHIFT] * r2_n;
            r3_n       <= r2_n;

            r_st[4]    <= r_st[3];
            r_kind[4]  <= r_kind[3];
            r_k1dur[4] <= r_k1dur[3];
            r4_t       <= 30'(n4_q * 8'd136);

            r_st[5]    <= r_st[4];
            r_kind[5]  <= r_kind[4];
            r_k1dur[5] <= r_k1dur[4];
            // Exact floor division by 10 for values below 2^32.
            r5_p       <= r4_t * 32'hCCCCCCCD;

            r_out      <= n_out;
        end
    end

    assign o_out_valid = r_vld[5];
    assign o_out_rsp   = r_out;

endmodule
